### design/bst_pkg.sv
package bst_pkg;

  localparam int unsigned MaxTokensDefault  = 4096;
  localparam int unsigned OffsetBitsDefault = 16;

  localparam logic [5:0] K_EOF = 6'd0;
  localparam logic [5:0] K_ERROR = 6'd1;
  localparam logic [5:0] K_IDENT = 6'd2;
  localparam logic [5:0] K_INT = 6'd3;
  localparam logic [5:0] K_STRING = 6'd4;
  localparam logic [5:0] K_TRUE = 6'd5;
  localparam logic [5:0] K_FALSE = 6'd6;
  localparam logic [5:0] K_PATH = 6'd7;
  localparam logic [5:0] K_FLAG = 6'd8;
  localparam logic [5:0] K_LPAREN = 6'd9;
  localparam logic [5:0] K_RPAREN = 6'd10;
  localparam logic [5:0] K_LBRACE = 6'd11;
  localparam logic [5:0] K_RBRACE = 6'd12;
  localparam logic [5:0] K_LBRACKET = 6'd13;
  localparam logic [5:0] K_RBRACKET = 6'd14;
  localparam logic [5:0] K_COMMA = 6'd15;
  localparam logic [5:0] K_COLON = 6'd16;
  localparam logic [5:0] K_DCOLON = 6'd17;
  localparam logic [5:0] K_BANG = 6'd18;
  localparam logic [5:0] K_NE = 6'd19;
  localparam logic [5:0] K_EQ = 6'd20;
  localparam logic [5:0] K_DEQ = 6'd21;
  localparam logic [5:0] K_GT = 6'd22;
  localparam logic [5:0] K_GE = 6'd23;
  localparam logic [5:0] K_LT = 6'd24;
  localparam logic [5:0] K_LE = 6'd25;
  localparam logic [5:0] K_MINUS = 6'd26;
  localparam logic [5:0] K_ARROW = 6'd27;
  localparam logic [5:0] K_AND = 6'd28;
  localparam logic [5:0] K_OR = 6'd29;
  localparam logic [5:0] K_PIPE = 6'd30;
  localparam logic [5:0] K_PLUS = 6'd31;
  localparam logic [5:0] K_PERCENT = 6'd32;
  localparam logic [5:0] K_CARET = 6'd33;
  localparam logic [5:0] K_TILDE = 6'd34;
  localparam logic [5:0] K_KW0 = 6'd35;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       is_alpha;
    logic       is_dig;
    logic       is_path;
    logic       is_flag;
    logic       is_blank;
  } beat_t;

  localparam int unsigned BeatW = $bits(beat_t);

  function automatic logic [5:0] word_kind(input logic [63:0] w, input logic [3:0] len);
    logic [5:0] k;
    k = K_IDENT;
    case (len)
      4'd2: begin
        if (w[15:0] == "fi") k = K_KW0;
        else if (w[15:0] == "cc") k = K_KW0 + 6'd7;
      end
      4'd3: if (w[23:0] == "tuo") k = K_KW0 + 6'd16;
      4'd4: begin
        if (w[31:0] == "dnib") k = K_KW0 + 6'd3;
        else if (w[31:0] == "dnik") k = K_KW0 + 6'd4;
        else if (w[31:0] == "edom") k = K_KW0 + 6'd5;
        else if (w[31:0] == "esle") k = K_KW0 + 6'd14;
        else if (w[31:0] == "eurt") k = K_TRUE;
      end
      4'd5: begin
        if (w[39:0] == "tnirp") k = K_KW0 + 6'd11;
        else if (w[39:0] == "eslaf") k = K_FALSE;
      end
      4'd6: begin
        if (w[47:0] == "sgalfc") k = K_KW0 + 6'd8;
        else if (w[47:0] == "sgalfl") k = K_KW0 + 6'd18;
        else if (w[47:0] == "reknil") k = K_KW0 + 6'd19;
        else if (w[47:0] == "tegrat") k = K_KW0 + 6'd20;
      end
      4'd7: begin
        if (w[55:0] == "llatsni") k = K_KW0 + 6'd1;
        else if (w[55:0] == "secruos") k = K_KW0 + 6'd6;
        else if (w[55:0] == "negedoc") k = K_KW0 + 6'd9;
        else if (w[55:0] == "senifed") k = K_KW0 + 6'd12;
        else if (w[55:0] == "sdneped") k = K_KW0 + 6'd13;
        else if (w[55:0] == "edulcxe") k = K_KW0 + 6'd15;
        else if (w[55:0] == "rid_tuo") k = K_KW0 + 6'd17;
      end
      4'd8: begin
        if (w == "sedulcni") k = K_KW0 + 6'd2;
        else if (w == "relipmoc") k = K_KW0 + 6'd10;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h3a: k = K_COLON;
      8'h21: k = K_BANG;
      8'h3d: k = K_EQ;
      8'h3e: k = K_GT;
      8'h3c: k = K_LT;
      8'h7c: k = K_PIPE;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_double(input logic [7:0] f, input logic [7:0] c);
    logic [5:0] k;
    k = K_EOF;
    case (f)
      8'h3a: if (c == 8'h3a) k = K_DCOLON;
      8'h21: if (c == 8'h3d) k = K_NE;
      8'h3d: if (c == 8'h3d) k = K_DEQ;
      8'h3e: if (c == 8'h3d) k = K_GE;
      8'h3c: if (c == 8'h3d) k = K_LE;
      8'h26: if (c == 8'h26) k = K_AND;
      8'h7c: if (c == 8'h7c) k = K_OR;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h00: k = K_EOF;
      8'h28: k = K_LPAREN;
      8'h29: k = K_RPAREN;
      8'h7b: k = K_LBRACE;
      8'h7d: k = K_RBRACE;
      8'h5b: k = K_LBRACKET;
      8'h5d: k = K_RBRACKET;
      8'h2c: k = K_COMMA;
      8'h2b: k = K_PLUS;
      8'h25: k = K_PERCENT;
      8'h5e: k = K_CARET;
      8'h7e: k = K_TILDE;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

### design/bst_front.sv
module bst_front
  import bst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_source_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output beat_t       q_beat_o
);

  // two-entry queue between classifier and lexer
  beat_t     mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  beat_t     b;
  logic      push, pop;
  logic [7:0] c;

  always_comb begin
    c = source_byte_i;
    b.ch = c;
    b.eos = end_of_source_i;
    b.is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    b.is_dig = c >= 8'h30 && c <= 8'h39;
    b.is_path = b.is_alpha || b.is_dig || c == 8'h2f || c == 8'h2e || c == 8'h2d;
    b.is_flag = b.is_path || c == 8'h3d || c == 8'h2c || c == 8'h3a || c == 8'h2b;
    b.is_blank = c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  end

  assign ready_o   = cnt_q != 2'd2;
  assign push      = valid_i && ready_o;
  assign q_valid_o = cnt_q != 2'd0;
  assign pop       = q_valid_o && q_ready_i;
  assign q_beat_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### design/bst_back.sv
module bst_back
  import bst_pkg::*;
#(
  parameter int unsigned MaxTokens  = MaxTokensDefault,
  parameter int unsigned OffsetBits = OffsetBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  beat_t       q_beat_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] token_offset_o,
  output logic [15:0] token_length_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic        is_final_o,
  output logic        limit_hit_o,
  output logic [11:0] error_total_o
);

  localparam int unsigned CntW = $clog2(MaxTokens + 1);

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_LCOM, M_BCOM, M_BSTAR, M_IDENT, M_NUM, M_PATH,
    M_MINUS, M_FLAG, M_OP, M_STR
  } mode_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] off;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        fin;
    logic        lim;
    logic [11:0] err;
  } tok_t;

  mode_e             mode_q, mode_d;
  logic [7:0]        held_q, held_d, quote_q, quote_d;
  logic [OffsetBits-1:0] off_q, off_d, start_q, start_d;
  logic [15:0]       line_q, line_d, col_q, col_d, scol_q, scol_d;
  logic [63:0]       word_q, word_d;
  logic [3:0]        wlen_q, wlen_d;
  logic              esc_q, esc_d, fin_q, fin_d;
  logic [CntW-1:0]   ntok_q, ntok_d;
  logic [11:0]       nerr_q, nerr_d;

  // output buffer: two slots
  tok_t              ob_q [2];
  logic [1:0]        ocnt_q;
  logic              orp_q;
  tok_t              t0, t1;
  logic [1:0]        nemit;

  logic              fire, pop;

  assign q_ready_o = ocnt_q == 2'd0 || (ocnt_q == 2'd1 && ready_i) || fin_q;
  assign fire = q_valid_i && q_ready_o;
  assign pop = valid_o && ready_i;
  assign valid_o = ocnt_q != 2'd0;

  always_comb begin
    tok_t    ot;
    logic    do_consume, stop, emit_p;
    logic [5:0] pk;
    logic [5:0] k2;
    logic [7:0] c;
    mode_e   m;
    logic [OffsetBits-1:0] tstart;
    logic [OffsetBits-1:0] span;
    logic [15:0] tcol, tlen, line_e;
    logic    op2;

    mode_d = mode_q; held_d = held_q; quote_d = quote_q; off_d = off_q;
    start_d = start_q; line_d = line_q; col_d = col_q; scol_d = scol_q;
    word_d = word_q; wlen_d = wlen_q; esc_d = esc_q; fin_d = fin_q;
    ntok_d = ntok_q; nerr_d = nerr_q;
    t0 = '0; t1 = '0; nemit = 2'd0; ot = '0;
    do_consume = 1'b0; stop = 1'b0; emit_p = 1'b0; pk = K_EOF; k2 = K_EOF;
    c = q_beat_i.ch; m = mode_q; op2 = 1'b0;
    tstart = '0; span = '0; tcol = '0; tlen = '0; line_e = line_q;

    // phase 1: the held token, decided by this byte
    if (q_beat_i.eos) begin
      emit_p = 1'b1;
      case (mode_q)
        M_IDENT: pk = word_kind(word_q, wlen_q);
        M_NUM: pk = K_INT;
        M_PATH, M_SLASH: pk = K_PATH;
        M_MINUS: pk = K_MINUS;
        M_FLAG: pk = K_FLAG;
        M_OP: pk = op_single(held_q);
        M_STR: pk = K_EOF;
        default: emit_p = 1'b0;
      endcase
      m = M_IDLE;
    end else begin
      case (mode_q)
        M_SLASH: begin
          if (c == 8'h2f) begin m = M_LCOM; stop = 1'b1; do_consume = 1'b1; end
          else if (c == 8'h2a) begin m = M_BCOM; stop = 1'b1; do_consume = 1'b1; end
          else if (q_beat_i.is_path) begin m = M_PATH; stop = 1'b1; do_consume = 1'b1; end
          else begin emit_p = 1'b1; pk = K_PATH; m = M_IDLE; end
        end
        M_LCOM: begin
          if (c == 8'h0a) m = M_IDLE;
          else begin stop = 1'b1; do_consume = 1'b1; end
        end
        M_BCOM: begin
          stop = 1'b1; do_consume = 1'b1;
          if (c == 8'h2a) m = M_BSTAR;
        end
        M_BSTAR: begin
          stop = 1'b1; do_consume = 1'b1;
          if (c == 8'h2f) m = M_IDLE;
          else if (c != 8'h2a) m = M_BCOM;
        end
        M_IDENT: begin
          if (q_beat_i.is_alpha || q_beat_i.is_dig) begin
            stop = 1'b1; do_consume = 1'b1;
            if (wlen_q < 4'd8) word_d = word_q | ({56'd0, c} << {wlen_q[2:0], 3'b000});
            if (wlen_q < 4'd15) wlen_d = wlen_q + 4'd1;
          end else if (c == 8'h2f || c == 8'h2e) begin
            m = M_PATH; stop = 1'b1; do_consume = 1'b1;
          end else begin emit_p = 1'b1; pk = word_kind(word_q, wlen_q); m = M_IDLE; end
        end
        M_NUM: begin
          if (q_beat_i.is_dig) begin stop = 1'b1; do_consume = 1'b1; end
          else begin emit_p = 1'b1; pk = K_INT; m = M_IDLE; end
        end
        M_PATH: begin
          if (q_beat_i.is_path) begin stop = 1'b1; do_consume = 1'b1; end
          else begin emit_p = 1'b1; pk = K_PATH; m = M_IDLE; end
        end
        M_MINUS: begin
          if (q_beat_i.is_alpha || q_beat_i.is_dig) begin
            m = M_FLAG; stop = 1'b1; do_consume = 1'b1;
          end else if (c == 8'h3e) begin
            stop = 1'b1; do_consume = 1'b1; op2 = 1'b1;
            emit_p = 1'b1; pk = K_ARROW; m = M_IDLE;
          end else begin emit_p = 1'b1; pk = K_MINUS; m = M_IDLE; end
        end
        M_FLAG: begin
          if (q_beat_i.is_flag) begin stop = 1'b1; do_consume = 1'b1; end
          else begin emit_p = 1'b1; pk = K_FLAG; m = M_IDLE; end
        end
        M_OP: begin
          k2 = op_double(held_q, c);
          if (k2 != K_EOF) begin
            stop = 1'b1; do_consume = 1'b1; op2 = 1'b1;
            emit_p = 1'b1; pk = k2; m = M_IDLE;
          end else begin emit_p = 1'b1; pk = op_single(held_q); m = M_IDLE; end
        end
        M_STR: begin
          if (esc_q) begin esc_d = 1'b0; stop = 1'b1; do_consume = 1'b1; end
          else if (c == quote_q) begin
            stop = 1'b1; do_consume = 1'b1; op2 = 1'b1;
            emit_p = 1'b1; pk = K_STRING; m = M_IDLE;
          end else if (c == 8'h0a) begin emit_p = 1'b1; pk = K_ERROR; m = M_IDLE; end
          else if (c == 8'h00) begin
            stop = 1'b1; emit_p = 1'b1; pk = K_EOF; m = M_IDLE;
          end else begin
            if (c == 8'h5c) esc_d = 1'b1;
            stop = 1'b1; do_consume = 1'b1;
          end
        end
        default: m = M_IDLE;
      endcase
    end

    // consumed bytes that close the held token count in its length
    span = (do_consume && op2) ? off_q + 1'b1 - start_q : off_q - start_q;
    tlen = 16'(span);
    if (do_consume && op2 && c == 8'h0a && line_q != 16'hffff) line_e = line_q + 16'd1;

    if (emit_p) begin
      t0.kind = pk;
      t0.off = 16'(start_q);
      t0.len = tlen;
      t0.line = line_e;
      t0.col = scol_q;
      nemit = 2'd1;
    end

    // phase 2: this byte from idle, or the end marker eof
    if (q_beat_i.eos) begin
      ot.kind = K_EOF;
      ot.off = 16'(off_q);
      ot.len = 16'd0;
      ot.line = line_q;
      ot.col = col_q;
      if (nemit == 2'd0) t0 = ot; else t1 = ot;
      nemit = nemit + 2'd1;
    end else if (!stop) begin
      do_consume = 1'b1;
      if (!q_beat_i.is_blank) begin
        tstart = off_q; tcol = col_q;
        start_d = off_q; scol_d = col_q;
        if (q_beat_i.is_alpha) begin
          word_d = {56'd0, c}; wlen_d = 4'd1; m = M_IDENT;
        end else if (q_beat_i.is_dig) m = M_NUM;
        else begin
          case (c)
            8'h27, 8'h22: begin quote_d = c; esc_d = 1'b0; m = M_STR; end
            8'h2f: m = M_SLASH;
            8'h2e: m = M_PATH;
            8'h2d: m = M_MINUS;
            8'h3a, 8'h21, 8'h3d, 8'h3e, 8'h3c, 8'h26, 8'h7c: begin
              held_d = c; m = M_OP;
            end
            default: begin
              ot.kind = single_kind(c);
              ot.off = 16'(tstart);
              ot.len = 16'd1;
              ot.line = line_q;
              ot.col = tcol;
              if (nemit == 2'd0) t0 = ot; else t1 = ot;
              nemit = nemit + 2'd1;
              m = M_IDLE;
            end
          endcase
        end
      end
    end

    if (do_consume) begin
      off_d = off_q + 1'b1;
      if (c == 8'h0a) begin
        if (line_q != 16'hffff) line_d = line_q + 16'd1;
        col_d = 16'd1;
      end else if (col_q != 16'hffff) col_d = col_q + 16'd1;
    end
    mode_d = m;

    // count tokens and errors in order, stop at the limit or eof
    begin
      logic [CntW-1:0] nt;
      logic [11:0] ne;
      logic f;
      logic l;
      nt = ntok_q; ne = nerr_q; f = 1'b0; l = 1'b0;
      if (nemit != 2'd0) begin
        nt = nt + 1'b1;
        l = nt >= CntW'(MaxTokens);
        if (!l && t0.kind == K_ERROR && ne != 12'hfff) ne = ne + 12'd1;
        t0.lim = l; t0.fin = t0.kind == K_EOF; t0.err = ne;
        f = l || t0.fin;
        if (f) nemit = 2'd1;
      end
      if (nemit == 2'd2) begin
        nt = nt + 1'b1;
        l = nt >= CntW'(MaxTokens);
        if (!l && t1.kind == K_ERROR && ne != 12'hfff) ne = ne + 12'd1;
        t1.lim = l; t1.fin = t1.kind == K_EOF; t1.err = ne;
        f = l || t1.fin;
      end
      ntok_d = nt; nerr_d = ne;
      if (f) fin_d = 1'b1;
    end
  end

  // new tokens go behind whatever is still buffered, popped or not
  always_ff @(posedge clk_i) begin
    if (fire && !fin_q) begin
      if (nemit != 2'd0) ob_q[orp_q ^ ocnt_q[0]] <= t0;
      if (nemit == 2'd2) ob_q[~(orp_q ^ ocnt_q[0])] <= t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; held_q <= '0; quote_q <= '0; off_q <= '0; start_q <= '0;
      line_q <= 16'd1; col_q <= 16'd1; scol_q <= '0; word_q <= '0; wlen_q <= '0;
      esc_q <= 1'b0; fin_q <= 1'b0; ntok_q <= CntW'(1); nerr_q <= '0;
      ocnt_q <= 2'd0; orp_q <= 1'b0;
    end else begin
      if (pop) orp_q <= ~orp_q;
      if (fire && !fin_q) begin
        mode_q <= mode_d; held_q <= held_d; quote_q <= quote_d; off_q <= off_d;
        start_q <= start_d; line_q <= line_d; col_q <= col_d; scol_q <= scol_d;
        word_q <= word_d; wlen_q <= wlen_d; esc_q <= esc_d; fin_q <= fin_d;
        ntok_q <= ntok_d; nerr_q <= nerr_d;
        ocnt_q <= ocnt_q + nemit - {1'b0, pop};
      end else begin
        ocnt_q <= ocnt_q - {1'b0, pop};
      end
    end
  end

  assign token_kind_o   = ob_q[orp_q].kind;
  assign token_offset_o = ob_q[orp_q].off;
  assign token_length_o = ob_q[orp_q].len;
  assign token_line_o   = ob_q[orp_q].line;
  assign token_column_o = ob_q[orp_q].col;
  assign is_final_o     = ob_q[orp_q].fin;
  assign limit_hit_o    = ob_q[orp_q].lim;
  assign error_total_o  = ob_q[orp_q].err;

endmodule

### design/build_script_tokenizer_unit.sv
// path: a byte is registered in the front queue and lexed from there; a token
// is registered in the output buffer and can be taken from there
// throughput: one byte per cycle while the two-slot token buffer drains;
// a byte that yields two tokens fills the buffer and holds the lexer until a token is taken
// reset: asynchronous, active low; positions, counters and the lexer state return to their start values
module build_script_tokenizer_unit
  import bst_pkg::*;
#(
  parameter int unsigned MaxTokens  = MaxTokensDefault,
  parameter int unsigned OffsetBits = OffsetBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_source_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [5:0]  token_kind_o,
  output logic [15:0] token_offset_o,
  output logic [15:0] token_length_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic        is_final_o,
  output logic        limit_hit_o,
  output logic [11:0] error_total_o
);

  logic  qv, qr;
  beat_t qb;

  bst_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .source_byte_i, .end_of_source_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_beat_o(qb)
  );

  bst_back #(.MaxTokens(MaxTokens), .OffsetBits(OffsetBits)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_beat_i(qb),
    .valid_o, .ready_i, .token_kind_o, .token_offset_o, .token_length_o,
    .token_line_o, .token_column_o, .is_final_o, .limit_hit_o, .error_total_o
  );

endmodule

### design/bst_checker.sv
module bst_checker
  import bst_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        ready_i,
  input logic [5:0]  token_kind_o,
  input logic        is_final_o,
  input logic        limit_hit_o,
  input logic [15:0] token_line_o,
  input logic [11:0] error_total_o
);

  a_final_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (is_final_o == (token_kind_o == K_EOF)))
    else $error("final flag mismatch");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> token_line_o != 16'd0)
    else $error("line zero");

  a_stop_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ready_i && (is_final_o || limit_hit_o)) |=> !valid_o)
    else $error("beat after final");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o && $stable(token_kind_o))
    else $error("stalled beat changed");

endmodule

bind build_script_tokenizer_unit bst_checker u_chk (.*);
